// ===== rtl/core/softened_gravity_pair_accel_defines.svh =====
// Assertion macros for the softened gravity pair acceleration block.
// Depends on nothing; included by the top level.
`ifndef SOFTENED_GRAVITY_PAIR_ACCEL_DEFINES_SVH
`define SOFTENED_GRAVITY_PAIR_ACCEL_DEFINES_SVH
`ifndef SYNTHESIS
`define SGPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SGPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SGPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SGPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sgpa_pkg.sv =====
// Shared widths, stage map and register indexes for the pair acceleration block.
// Depends on nothing.
package sgpa_pkg;
    localparam int MAG_W    = 32;
    localparam int C_W      = 66;
    localparam int ROOT_W   = 43;
    localparam int SREM_W   = 45;
    localparam int DEN_W    = 109;
    localparam int NUM_W    = 122;
    localparam int Q_W      = 33;
    localparam int DSH_W    = DEN_W + Q_W;
    localparam int LANES    = 3;

    localparam int ST_SQRT0 = 4;
    localparam int ST_DENA  = ST_SQRT0 + ROOT_W;
    localparam int ST_DENB  = ST_DENA + 1;
    localparam int ST_OV    = ST_DENB + 1;
    localparam int ST_DIV0  = ST_OV + 1;
    localparam int ST_OUT   = ST_DIV0 + Q_W;
    localparam int NS       = ST_OUT + 1;

    localparam logic CFG_SOFTENING_SQ = 1'b0;
    localparam logic CFG_GRAV_CONST   = 1'b1;
endpackage

// ===== rtl/core/sgpa_sqrt_step.sv =====
// One registered digit of the floor square root (two radicand bits per step).
// Depends on sgpa_pkg.
module sgpa_sqrt_step
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [1:0]                       pair,
    input  logic [sgpa_pkg::ROOT_W-1:0]      root_in,
    input  logic [sgpa_pkg::SREM_W-1:0]      rem_in,
    output logic [sgpa_pkg::ROOT_W-1:0]      root_out,
    output logic [sgpa_pkg::SREM_W-1:0]      rem_out
);
    logic [sgpa_pkg::SREM_W+1:0] work;
    logic [sgpa_pkg::SREM_W+1:0] trial;
    logic                        take;
    logic [sgpa_pkg::ROOT_W-1:0] root_reg;
    logic [sgpa_pkg::SREM_W-1:0] rem_reg;

    always_comb
    begin
        work  = {rem_in, pair};
        trial = {{(sgpa_pkg::SREM_W-sgpa_pkg::ROOT_W){1'b0}}, root_in, 2'b01};
        take  = (work >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= {root_in[sgpa_pkg::ROOT_W-2:0], take};
            rem_reg  <= take ? sgpa_pkg::SREM_W'(work - trial)
                             : sgpa_pkg::SREM_W'(work);
        end
    end

    assign root_out = root_reg;
    assign rem_out  = rem_reg;
endmodule

// ===== rtl/core/sgpa_div_step.sv =====
// One registered restoring-division bit for all three axis lanes.
// Depends on sgpa_pkg.
module sgpa_div_step
(
    input  logic                                               clk,
    input  logic                                               en,
    input  logic [sgpa_pkg::DSH_W-1:0]                         dsh,
    input  logic [sgpa_pkg::LANES-1:0][sgpa_pkg::NUM_W-1:0]    rem_in,
    input  logic [sgpa_pkg::LANES-1:0][sgpa_pkg::Q_W-1:0]      q_in,
    output logic [sgpa_pkg::LANES-1:0][sgpa_pkg::NUM_W-1:0]    rem_out,
    output logic [sgpa_pkg::LANES-1:0][sgpa_pkg::Q_W-1:0]      q_out
);
    logic [sgpa_pkg::LANES-1:0]                      take;
    logic [sgpa_pkg::LANES-1:0][sgpa_pkg::NUM_W-1:0] rem_reg;
    logic [sgpa_pkg::LANES-1:0][sgpa_pkg::Q_W-1:0]   q_reg;

    always_comb
    begin
        for (int l = 0; l < sgpa_pkg::LANES; l++)
        begin
            take[l] = ({{(sgpa_pkg::DSH_W-sgpa_pkg::NUM_W){1'b0}}, rem_in[l]} >= dsh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < sgpa_pkg::LANES; l++)
            begin
                rem_reg[l] <= take[l] ? rem_in[l] - dsh[sgpa_pkg::NUM_W-1:0] : rem_in[l];
                q_reg[l]   <= {q_in[l][sgpa_pkg::Q_W-2:0], take[l]};
            end
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
endmodule

// ===== rtl/core/softened_gravity_pair_accel.sv =====
// Softened gravitational pair acceleration: one source body and one target in,
// one saturated Q12.20 acceleration vector out. Depends on sgpa_pkg, the
// square-root and division step modules, and the assertion macro header.
//
// The block is an 84-stage pipeline that takes one pair per cycle while in_stall
// is low; the depth is set by the 43-step square root and the 33-step divider
// that follows it. Stages with a bubble close up while the output is stalled,
// so input beats keep entering until every stage holds one.
// Write configuration only while the pipeline is empty.
`include "softened_gravity_pair_accel_defines.svh"
module softened_gravity_pair_accel
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        src_mass,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    input  logic signed [31:0] dst_x,
    input  logic signed [31:0] dst_y,
    input  logic signed [31:0] dst_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic               saturated
);
    localparam int NS    = sgpa_pkg::NS;
    localparam int LN    = sgpa_pkg::LANES;
    localparam int MAG_W = sgpa_pkg::MAG_W;
    localparam int C_W   = sgpa_pkg::C_W;
    localparam int RW    = sgpa_pkg::ROOT_W;
    localparam int SRW   = sgpa_pkg::SREM_W;
    localparam int DW    = sgpa_pkg::DEN_W;
    localparam int NW    = sgpa_pkg::NUM_W;
    localparam int QW    = sgpa_pkg::Q_W;
    localparam int DSW   = sgpa_pkg::DSH_W;

    logic [31:0] softening_sq_reg;
    logic [31:0] grav_const_reg;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_sq_reg <= 32'd655;
            grav_const_reg   <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgpa_pkg::CFG_SOFTENING_SQ: softening_sq_reg <= cfg_data;
                sgpa_pkg::CFG_GRAV_CONST:   grav_const_reg   <= cfg_data;
                default:                    grav_const_reg   <= grav_const_reg;
            endcase
        end
    end

    // advance a stage when it is empty or the one after it advances
    always_comb
    begin
        en[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                v_next[k] = en[k] ? in_valid : v_reg[k];
            end
            else
            begin
                v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // stage 0: displacement magnitude and sign
    logic [LN-1:0][31:0]    s_pos;
    logic [LN-1:0][31:0]    t_pos;
    logic [LN-1:0][32:0]    d_pos;
    logic [LN-1:0][32:0]    d_neg;
    logic [LN-1:0][MAG_W-1:0] mag0_reg;
    logic [LN-1:0]          neg0_reg;
    logic [31:0]            m0_reg;

    always_comb
    begin
        s_pos = {src_z, src_y, src_x};
        t_pos = {dst_z, dst_y, dst_x};
        for (int l = 0; l < LN; l++)
        begin
            d_pos[l] = {s_pos[l][31], s_pos[l]} - {t_pos[l][31], t_pos[l]};
            d_neg[l] = 33'd0 - d_pos[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m0_reg <= src_mass;
            for (int l = 0; l < LN; l++)
            begin
                neg0_reg[l] <= d_pos[l][32];
                mag0_reg[l] <= d_pos[l][32] ? d_neg[l][31:0] : d_pos[l][31:0];
            end
        end
    end

    // stage 1: squares and G*m
    logic [LN-1:0][63:0]      sq1_reg;
    logic [63:0]              gm1_reg;
    logic [LN-1:0][MAG_W-1:0] mag1_reg;
    logic [LN-1:0]            neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            gm1_reg  <= grav_const_reg * m0_reg;
            mag1_reg <= mag0_reg;
            neg1_reg <= neg0_reg;
            for (int l = 0; l < LN; l++)
            begin
                sq1_reg[l] <= mag0_reg[l] * mag0_reg[l];
            end
        end
    end

    // stage 2: clamped r^2 and numerator partial products
    logic [C_W-1:0]      r2_sum;
    logic [C_W-1:0]      eps40;
    logic [C_W-1:0]      c2_reg;
    logic                cz2_reg;
    logic [LN-1:0][63:0] plo2_reg;
    logic [LN-1:0][63:0] phi2_reg;
    logic [LN-1:0]       neg2_reg;

    always_comb
    begin
        r2_sum = {2'b0, sq1_reg[0]} + {2'b0, sq1_reg[1]} + {2'b0, sq1_reg[2]};
        eps40  = {14'b0, softening_sq_reg, 20'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c2_reg   <= (r2_sum >= eps40) ? r2_sum : eps40;
            cz2_reg  <= (r2_sum == '0) && (eps40 == '0);
            neg2_reg <= neg1_reg;
            for (int l = 0; l < LN; l++)
            begin
                plo2_reg[l] <= gm1_reg[31:0] * mag1_reg[l];
                phi2_reg[l] <= gm1_reg[63:32] * mag1_reg[l];
            end
        end
    end

    // stage 3: numerator assembly; c pipe index 0 is this stage
    logic [C_W-1:0]      c_pipe  [0:RW];
    logic [LN-1:0][NW-1:0] num_pipe [0:RW];
    logic [LN-1:0]       neg_pipe [0:RW];
    logic                cz_pipe  [0:RW];
    logic [RW-1:0]       root_w   [0:RW];
    logic [SRW-1:0]      rem_w    [0:RW];
    logic [LN-1:0][95:0] nsum;

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            nsum[l] = {phi2_reg[l], 32'b0} + {32'b0, plo2_reg[l]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c_pipe[0]   <= c2_reg;
            cz_pipe[0]  <= cz2_reg;
            neg_pipe[0] <= neg2_reg;
            for (int l = 0; l < LN; l++)
            begin
                num_pipe[0][l] <= {nsum[l], 26'b0};
            end
        end
    end

    assign root_w[0] = '0;
    assign rem_w[0]  = '0;

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        localparam int P = RW - 1 - i;
        logic [C_W+19:0] nfull;
        assign nfull = {c_pipe[i], 20'b0};

        sgpa_sqrt_step u_step
        (
            .clk      (clk),
            .en       (en[sgpa_pkg::ST_SQRT0+i]),
            .pair     (nfull[2*P+1:2*P]),
            .root_in  (root_w[i]),
            .rem_in   (rem_w[i]),
            .root_out (root_w[i+1]),
            .rem_out  (rem_w[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[sgpa_pkg::ST_SQRT0+i])
            begin
                c_pipe[i+1]   <= c_pipe[i];
                num_pipe[i+1] <= num_pipe[i];
                neg_pipe[i+1] <= neg_pipe[i];
                cz_pipe[i+1]  <= cz_pipe[i];
            end
        end
    end

    // denominator c*s over two stages of 22x22 partial products
    logic [2:0][21:0]      c_chunk;
    logic [1:0][21:0]      s_chunk;
    logic [2:0][1:0][43:0] ppa_reg;
    logic [LN-1:0][NW-1:0] numa_reg;
    logic [LN-1:0]         nega_reg;
    logic                  cza_reg;

    always_comb
    begin
        c_chunk = c_pipe[RW];
        s_chunk = {1'b0, root_w[RW]};
    end

    always_ff @(posedge clk)
    begin
        if (en[sgpa_pkg::ST_DENA])
        begin
            numa_reg <= num_pipe[RW];
            nega_reg <= neg_pipe[RW];
            cza_reg  <= cz_pipe[RW];
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    ppa_reg[a][b] <= c_chunk[a] * s_chunk[b];
                end
            end
        end
    end

    logic [DW:0]           den_sum;
    logic [DW-1:0]         denb_reg;
    logic [LN-1:0][NW-1:0] numb_reg;
    logic [LN-1:0]         negb_reg;
    logic                  czb_reg;

    always_comb
    begin
        den_sum = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                den_sum = den_sum + ((DW+1)'(ppa_reg[a][b]) << (22 * (a + b)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[sgpa_pkg::ST_DENB])
        begin
            denb_reg <= den_sum[DW-1:0];
            numb_reg <= numa_reg;
            negb_reg <= nega_reg;
            czb_reg  <= cza_reg;
        end
    end

    // quotient overflow check, then one quotient bit per stage
    logic [DW-1:0]         den_pipe [0:QW];
    logic [LN-1:0]         ov_pipe  [0:QW];
    logic [LN-1:0]         negd_pipe[0:QW];
    logic                  czd_pipe [0:QW];
    logic [LN-1:0][NW-1:0] drem_w   [0:QW];
    logic [LN-1:0][QW-1:0] q_w      [0:QW];
    logic [LN-1:0][NW-1:0] rem0_reg;
    logic [DSW-1:0]        den_top;

    assign den_top = {denb_reg, {QW{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en[sgpa_pkg::ST_OV])
        begin
            den_pipe[0]  <= denb_reg;
            negd_pipe[0] <= negb_reg;
            czd_pipe[0]  <= czb_reg;
            rem0_reg     <= numb_reg;
            for (int l = 0; l < LN; l++)
            begin
                ov_pipe[0][l] <= ({{(DSW-NW){1'b0}}, numb_reg[l]} >= den_top);
            end
        end
    end

    assign drem_w[0] = rem0_reg;
    assign q_w[0]    = '0;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [DSW-1:0] dsh;
        assign dsh = {{QW{1'b0}}, den_pipe[j]} << (QW - 1 - j);

        sgpa_div_step u_step
        (
            .clk     (clk),
            .en      (en[sgpa_pkg::ST_DIV0+j]),
            .dsh     (dsh),
            .rem_in  (drem_w[j]),
            .q_in    (q_w[j]),
            .rem_out (drem_w[j+1]),
            .q_out   (q_w[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (en[sgpa_pkg::ST_DIV0+j])
            begin
                den_pipe[j+1]  <= den_pipe[j];
                ov_pipe[j+1]   <= ov_pipe[j];
                negd_pipe[j+1] <= negd_pipe[j];
                czd_pipe[j+1]  <= czd_pipe[j];
            end
        end
    end

    // output stage: sign, saturation, zero-radius case
    logic [LN-1:0][31:0] acc_val;
    logic [LN-1:0]       lane_sat;
    logic [LN-1:0][31:0] acc_reg;
    logic                sat_reg;

    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            logic [QW-1:0] lim;
            logic [31:0]   mag_a;
            lim         = negd_pipe[QW][l] ? 33'h080000000 : 33'h07FFFFFFF;
            lane_sat[l] = ov_pipe[QW][l] || (q_w[QW][l] > lim);
            mag_a       = lane_sat[l] ? lim[31:0] : q_w[QW][l][31:0];
            acc_val[l]  = negd_pipe[QW][l] ? 32'd0 - mag_a : mag_a;
            if (czd_pipe[QW])
            begin
                acc_val[l]  = '0;
                lane_sat[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[sgpa_pkg::ST_OUT])
        begin
            acc_reg <= acc_val;
            sat_reg <= |lane_sat;
        end
    end

    assign accel_x   = acc_reg[0];
    assign accel_y   = acc_reg[1];
    assign accel_z   = acc_reg[2];
    assign saturated = sat_reg;

    `SGPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `SGPA_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, (&v_reg) && out_stall)
    `SGPA_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, v_reg[0])
endmodule

// ===== bench/softened_gravity_pair_accel_checker.sv =====
// Checker for the softened gravity pair acceleration block: watches the
// register port and both channels, predicts each acceleration and compares.
// Depends on sgpa_pkg for the register indexes.
module softened_gravity_pair_accel_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [31:0]        src_mass,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    input  logic signed [31:0] dst_x,
    input  logic signed [31:0] dst_y,
    input  logic signed [31:0] dst_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending,
    output int                 checked,
    output int                 clipped
);

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        sat;
    } accel_t;

    logic [31:0] eps_sq;
    logic [31:0] g_const;
    accel_t      accel_q[$];

    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic accel_t pair_accel(logic [31:0] m, logic signed [31:0] sx,
        logic signed [31:0] sy, logic signed [31:0] sz, logic signed [31:0] tx,
        logic signed [31:0] ty, logic signed [31:0] tz);
        logic signed [32:0] d[3];
        logic [32:0]        mag[3];
        logic [31:0]        lane[3];
        logic [127:0]       r2, eps40, c, s, den, num, q, lim, a;
        logic [63:0]        gm;
        accel_t             r;
        d[0] = 33'(sx) - 33'(tx);
        d[1] = 33'(sy) - 33'(ty);
        d[2] = 33'(sz) - 33'(tz);
        r2 = '0;
        for (int l = 0; l < 3; l++)
        begin
            mag[l] = d[l][32] ? 33'(-d[l]) : 33'(d[l]);
            r2 = r2 + 128'(mag[l]) * 128'(mag[l]);
        end
        eps40 = 128'(eps_sq) << 20;
        c = (r2 >= eps40) ? r2 : eps40;
        r = '0;
        if (c == 0)
            return r;
        s   = floor_sqrt(c << 20);
        den = c * s;
        gm  = 64'(g_const) * 64'(m);
        for (int l = 0; l < 3; l++)
        begin
            num = (128'(gm) * 128'(mag[l])) << 26;
            q   = num / den;
            lim = d[l][32] ? 128'h8000_0000 : 128'h7FFF_FFFF;
            a   = q;
            if (q > lim)
            begin
                a = lim;
                r.sat = 1'b1;
            end
            lane[l] = d[l][32] ? 32'(-a) : 32'(a);
        end
        r.ax = lane[0];
        r.ay = lane[1];
        r.az = lane[2];
        return r;
    endfunction

    assign pending = accel_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        accel_t want;
        if (!rst_n)
        begin
            eps_sq     <= 32'd655;
            g_const    <= 32'd1048576;
            fail_count <= 0;
            checked    <= 0;
            clipped    <= 0;
            accel_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sgpa_pkg::CFG_SOFTENING_SQ)
                    eps_sq <= cfg_data;
                else if (cfg_index == sgpa_pkg::CFG_GRAV_CONST)
                    g_const <= cfg_data;
            end
            if (in_valid && !in_stall)
                accel_q.push_back(pair_accel(src_mass, src_x, src_y, src_z,
                                             dst_x, dst_y, dst_z));
            if (out_valid && !out_stall)
            begin
                if (accel_q.size() == 0)
                begin
                    $display("%0t: unexpected beat %h %h %h %b", $time,
                             accel_x, accel_y, accel_z, saturated);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = accel_q.pop_front();
                    checked <= checked + 1;
                    clipped <= clipped + want.sat;
                    if (want != {accel_x, accel_y, accel_z, saturated})
                    begin
                        $display("%0t: expected %h %h %h %b actual %h %h %h %b", $time,
                                 want.ax, want.ay, want.az, want.sat,
                                 accel_x, accel_y, accel_z, saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/softened_gravity_pair_accel_tb.sv =====
// Testbench top for the softened gravity pair acceleration block: clock, reset,
// register writes, stimulus with random idling, random output stalls, and the verdict.
// Depends on sgpa_pkg, the block and softened_gravity_pair_accel_checker.
module softened_gravity_pair_accel_tb;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        src_mass;
    logic signed [31:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] accel_x, accel_y, accel_z;
    logic               saturated;
    int                 fail_count, pending, checked, clipped;
    int                 beats;
    bit                 quiet;

    softened_gravity_pair_accel DUT (.*);
    softened_gravity_pair_accel_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beats <= 0;
        else if (in_valid && !in_stall)
            beats <= beats + 1;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_pair(logic [31:0] m, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] sz, logic [31:0] tx, logic [31:0] ty,
                             logic [31:0] tz);
        int n0;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        src_mass = m;
        src_x = sx; src_y = sy; src_z = sz;
        dst_x = tx; dst_y = ty; dst_z = tz;
        in_valid = 1'b1;
        n0 = beats;
        do @(negedge clk); while (beats == n0);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (sgpa_pkg::NS + 8) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_pair();
        logic [31:0] m, sx, sy, sz, tx, ty, tz;
        int          mode;
        mode = $urandom_range(0, 9);
        m  = (mode < 3) ? $urandom_range(0, 32'h0400_0000) : $urandom;
        sx = $urandom; sy = $urandom; sz = $urandom;
        if (mode < 4)
        begin
            tx = $urandom; ty = $urandom; tz = $urandom;
        end
        else
        begin
            tx = sx + $signed($urandom_range(0, 1 << (mode * 2)) - (1 << (mode * 2 - 1)));
            ty = ($urandom_range(0, 3) == 0) ? sy : sy + $urandom_range(0, 1 << mode * 2);
            tz = sz - $urandom_range(0, 1 << (mode * 2));
        end
        send_pair(m, sx, sy, sz, tx, ty, tz);
    endtask

    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PMIN = 32'h8000_0000;

    task automatic directed_pairs();
        send_pair(32'h0100_0000, 0, 0, 0, 0, 0, 0);
        send_pair(32'hFFFF_FFFF, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN);
        send_pair(32'hFFFF_FFFF, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
        send_pair(32'hFFFF_FFFF, PMAX, PMIN, 0, PMIN, PMAX, 0);
        send_pair(32'hFFFF_FFFF, 32'd1, 0, 0, 0, 0, 0);
        send_pair(32'hFFFF_FFFF, 0, 0, 0, 0, 32'd1, 0);
        send_pair(0, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 0, 0, 0);
        send_pair(32'h0100_0000, 32'h0010_0000, 0, 0, 0, 0, 0);
        send_pair(32'h0100_0000, 0, 32'h0040_0000, 0, 0, 0, 0);
        send_pair(32'h0100_0000, 5, 7, 32'hFFFF_FFF0, 5, 7, 32'hFFFF_FFF0);
        send_pair(32'h0000_0001, PMAX, 0, 0, PMIN, 0, 0);
        send_pair(32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFD, 32'd1, 0, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0; quiet = 1'b0;
        cfg_we = 1'b0; cfg_index = sgpa_pkg::CFG_SOFTENING_SQ; cfg_data = '0;
        in_valid = 1'b0; src_mass = '0;
        src_x = '0; src_y = '0; src_z = '0; dst_x = '0; dst_y = '0; dst_z = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_pairs();
        drain();
        write_reg(sgpa_pkg::CFG_SOFTENING_SQ, 32'd0);
        write_reg(sgpa_pkg::CFG_GRAV_CONST, 32'hFFFF_FFFF);
        directed_pairs();
        drain();
        write_reg(sgpa_pkg::CFG_SOFTENING_SQ, 32'hFFFF_FFFF);
        write_reg(sgpa_pkg::CFG_GRAV_CONST, 32'd0);
        send_pair(32'hFFFF_FFFF, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN);
        send_pair(32'hFFFF_FFFF, 32'd1, 0, 0, 0, 0, 0);
        drain();
        write_reg(sgpa_pkg::CFG_GRAV_CONST, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'd1, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(sgpa_pkg::CFG_SOFTENING_SQ,
                      (ph % 2) ? $urandom : $urandom_range(0, 4096));
            write_reg(sgpa_pkg::CFG_GRAV_CONST, (ph == 5) ? 32'd1048576 : $urandom);
            if (ph == 5)
                quiet = 1'b1;
            for (int i = 0; i < 70; i++)
                random_pair();
            drain();
        end

        $display("Run checked %0d accelerations, %0d of them clipped,", checked, clipped);
        $display("across reset, extreme and random softening and G settings.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
